// ----- hdl/sed_pkg.sv -----
// Shared types, character codes and digit helpers for the string escape decoder.
// No dependencies; imported by every module of the decoder.
package sed_pkg;

    // character codes seen in the literal body
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    // decoded control bytes
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // decode queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one decoded request: up to three bytes, or one empty end marker
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last;
        logic            present;
        logic            fin;
    } sed_entry_t;

    // value of one digit character, 0 to 35
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_LA && c <= CH_LZ)
            d = c - CH_LA + 8'd10;
        else if (c >= CH_UA && c <= CH_UZ)
            d = c - CH_UA + 8'd10;
        else if (c >= CH_0 && c <= CH_9)
            d = c - CH_0;
        return d[5:0];
    endfunction

    // two hex digits, mod 256
    function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
        logic [9:0] s;
        s = {digit_value(a), 4'b0000} + {4'b0000, digit_value(b)};
        return s[7:0];
    endfunction

    // three octal digits, mod 256
    function automatic logic [7:0] oct_triple(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [12:0] s;
        s = {1'b0, digit_value(a), 6'b000000} + {4'b0000, digit_value(b), 3'b000}
            + {7'b0000000, digit_value(c)};
        return s[7:0];
    endfunction

endpackage

// ----- hdl/sed_front.sv -----
// Front end: accepts characters, tracks the open escape and builds decoded requests.
// Depends on sed_pkg.
module sed_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          character,
    input  logic                final_char,
    output logic                req_valid,
    output sed_pkg::sed_entry_t req
);
    import sed_pkg::*;

    logic            esc_reg;
    logic            esc_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic            main_valid;
    logic [7:0]      main_byte;

    // escape sequencing for the current character
    always_comb
    begin
        esc_next   = esc_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        main_valid = 1'b0;
        main_byte  = character;
        if (!esc_reg)
        begin
            if (character == CH_BSLASH)
            begin
                esc_next = 1'b1;
                cnt_next = 2'd0;
            end
            else
            begin
                main_valid = 1'b1;
            end
        end
        else
        begin
            unique case (cnt_reg)
                2'd0:
                begin
                    unique case (character) inside
                        CH_N:
                        begin
                            main_valid = 1'b1;
                            main_byte  = BYTE_LF;
                            esc_next   = 1'b0;
                        end
                        CH_R:
                        begin
                            main_valid = 1'b1;
                            main_byte  = BYTE_CR;
                            esc_next   = 1'b0;
                        end
                        CH_T:
                        begin
                            main_valid = 1'b1;
                            main_byte  = BYTE_TAB;
                            esc_next   = 1'b0;
                        end
                        CH_0, CH_1, CH_2, CH_3, CH_DOLLAR:
                        begin
                            pend_next[0] = character;
                            cnt_next     = 2'd1;
                        end
                        default:
                        begin
                            main_valid = 1'b1;
                            esc_next   = 1'b0;
                        end
                    endcase
                end
                2'd1:
                begin
                    pend_next[1] = character;
                    cnt_next     = 2'd2;
                end
                2'd2:
                begin
                    if (pend_reg[0] == CH_DOLLAR)
                    begin
                        main_valid = 1'b1;
                        main_byte  = hex_pair(pend_reg[1], character);
                        esc_next   = 1'b0;
                    end
                    else if (pend_reg[0] == CH_0 &&
                             (pend_reg[1] == CH_LX || pend_reg[1] == CH_UX))
                    begin
                        pend_next[2] = character;
                        cnt_next     = 2'd3;
                    end
                    else
                    begin
                        main_valid = 1'b1;
                        main_byte  = oct_triple(pend_reg[0], pend_reg[1], character);
                        esc_next   = 1'b0;
                    end
                end
                default:
                begin
                    main_valid = 1'b1;
                    main_byte  = hex_pair(pend_reg[2], character);
                    esc_next   = 1'b0;
                end
            endcase
            if (!esc_next)
                cnt_next = 2'd0;
        end
    end

    // request build: main byte, or flush of a cut-short escape at the end
    always_comb
    begin
        logic [1:0] slot;
        logic [2:0] nbytes;
        req       = '0;
        req.fin   = final_char;
        slot      = 2'd0;
        nbytes    = 3'd0;
        if (main_valid)
        begin
            req.bytes[0] = main_byte;
            nbytes       = 3'd1;
        end
        else if (final_char && esc_next)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < cnt_next && pend_next[i] != CH_BSLASH)
                begin
                    req.bytes[slot] = pend_next[i];
                    slot            = slot + 2'd1;
                    nbytes          = nbytes + 3'd1;
                end
            end
        end
        if (nbytes == 3'd0)
        begin
            req.present = 1'b0;
            req.last    = 2'd0;
        end
        else
        begin
            req.present = 1'b1;
            req.last    = 2'(nbytes - 3'd1);
        end
        req_valid = accept && (main_valid || final_char);
    end

    // escape state, cleared after the last character of a literal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            if (final_char)
            begin
                esc_reg <= 1'b0;
                cnt_reg <= 2'd0;
            end
            else
            begin
                esc_reg <= esc_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // buffered escape characters
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

endmodule

// ----- hdl/sed_queue.sv -----
// Short request queue that decouples the front end from the result sequencer.
// Depends on sed_pkg.
module sed_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  sed_pkg::sed_entry_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output sed_pkg::sed_entry_t rd_data,
    output logic                empty
);
    import sed_pkg::*;

    sed_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_wr;
    logic                do_rd;

    // status and head
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hdl/sed_back.sv -----
// Result sequencer: walks the bytes of the head request, one result per pop.
// Depends on sed_pkg.
module sed_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sed_pkg::sed_entry_t head,
    input  logic                head_empty,
    output logic                head_pop,
    input  logic                pop,
    output logic [7:0]          out_byte,
    output logic                byte_present,
    output logic                end_of_literal
);
    import sed_pkg::*;

    logic [1:0] idx_reg;
    logic       at_last;

    assign at_last = (idx_reg == head.last);

    // current result from the head request
    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = head.bytes[0];
            2'd1:    out_byte = head.bytes[1];
            default: out_byte = head.bytes[2];
        endcase
        byte_present   = head.present;
        end_of_literal = head.fin && at_last;
        head_pop       = pop && !head_empty && at_last;
    end

    // byte index within the head request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (pop && !head_empty)
        begin
            if (at_last)
                idx_reg <= 2'd0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ----- hdl/string_escape_decoder_core.sv -----
// Top level of the string escape decoder: front end, request queue, result sequencer.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
//
// Usage: the body of one quoted literal enters one character per request on the
// input queue port (push/full, character, final_char marks the last character).
// Decoded bytes leave on the result queue port (empty/pop, out_byte, byte_present,
// end_of_literal). A character that completes a byte is queued and shows up on the result
// ports once the requests ahead of it are popped. The input side takes one character per
// cycle as long as results are popped; each request yields at most one byte, except the
// final character of a literal ending inside an open escape, which yields up to three
// bytes, popped one after another. A final character that yields nothing gives one empty
// end marker (byte_present 0, end_of_literal 1).
// A four-entry request queue sits between the front end and the result sequencer;
// when pop stays low the queue fills and full rises, holding off further characters.
// Reset clears the escape state and empties the queue; the block is ready as soon as
// reset is released.
module string_escape_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] character,
    input  logic       final_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       byte_present,
    output logic       end_of_literal
);
    import sed_pkg::*;

    logic       accept;
    logic       req_valid;
    sed_entry_t req;
    sed_entry_t head;
    logic       head_pop;

    assign accept = push && !full;

    // character classification and escape tracking
    sed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .character  (character),
        .final_char (final_char),
        .req_valid  (req_valid),
        .req        (req)
    );

    // decoupling queue
    sed_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (req_valid),
        .wr_data (req),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head),
        .empty   (empty)
    );

    // result sequencing
    sed_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_empty     (empty),
        .head_pop       (head_pop),
        .pop            (pop),
        .out_byte       (out_byte),
        .byte_present   (byte_present),
        .end_of_literal (end_of_literal)
    );

endmodule

// ----- tb/sv/tb_string_escape_decoder_core.sv -----
// Testbench for string_escape_decoder_core: literal bodies in, decoded bytes checked in order.
// Depends on sed_pkg (character codes) and the string_escape_decoder_core RTL.

import sed_pkg::*;

// one decoded byte or end marker, as seen on the result ports
typedef struct packed {
    logic [7:0] value;
    logic       present;
    logic       last;
} decoded_byte_t;

// tracks the escape state of the literal and the bytes still due on the result side
class decoded_byte_tracker;
    bit            in_escape;
    logic [7:0]    held[3];
    int unsigned   held_count;
    decoded_byte_t due_bytes[$];
    int unsigned   errors;

    function new();
        in_escape  = 1'b0;
        held_count = 0;
        errors     = 0;
        foreach (held[i]) held[i] = 8'h00;
    endfunction

    // weight of one digit character: 0-9, letters 10-35, anything else 0
    function int char_weight(logic [7:0] c);
        if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
        if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
        if (c >= CH_0 && c <= CH_9) return c - CH_0;
        return 0;
    endfunction

    function logic [7:0] weigh_pair(logic [7:0] a, logic [7:0] b);
        int v;
        v = char_weight(a) * 16 + char_weight(b);
        return v[7:0];
    endfunction

    function logic [7:0] weigh_triple(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int v;
        v = (char_weight(a) * 8 + char_weight(b)) * 8 + char_weight(c);
        return v[7:0];
    endfunction

    // work out the bytes that one accepted request yields
    function void decode_char(logic [7:0] ch, logic fin);
        logic [7:0]    produced[$];
        decoded_byte_t entry;
        int unsigned   i;
        bit            shut;
        shut = 1'b0;
        if (!in_escape) begin
            if (ch == CH_BSLASH) begin
                in_escape  = 1'b1;
                held_count = 0;
            end
            else
                produced.push_back(ch);
        end
        else begin
            case (held_count)
                0: begin
                    if (ch == CH_N) begin
                        produced.push_back(BYTE_LF);
                        shut = 1'b1;
                    end
                    else if (ch == CH_R) begin
                        produced.push_back(BYTE_CR);
                        shut = 1'b1;
                    end
                    else if (ch == CH_T) begin
                        produced.push_back(BYTE_TAB);
                        shut = 1'b1;
                    end
                    else if ((ch >= CH_0 && ch <= CH_3) || ch == CH_DOLLAR) begin
                        held[0]    = ch;
                        held_count = 1;
                    end
                    else begin
                        produced.push_back(ch);
                        shut = 1'b1;
                    end
                end
                1: begin
                    held[1]    = ch;
                    held_count = 2;
                end
                2: begin
                    if (held[0] == CH_DOLLAR) begin
                        produced.push_back(weigh_pair(held[1], ch));
                        shut = 1'b1;
                    end
                    else if (held[0] == CH_0 && (held[1] == CH_LX || held[1] == CH_UX)) begin
                        held[2]    = ch;
                        held_count = 3;
                    end
                    else begin
                        produced.push_back(weigh_triple(held[0], held[1], ch));
                        shut = 1'b1;
                    end
                end
                default: begin
                    produced.push_back(weigh_pair(held[2], ch));
                    shut = 1'b1;
                end
            endcase
        end
        if (shut) begin
            in_escape  = 1'b0;
            held_count = 0;
        end

        // end of literal: flush an open escape as plain text, backslash dropped
        if (fin) begin
            if (in_escape) begin
                for (i = 0; i < held_count; i++)
                    if (held[i] != CH_BSLASH)
                        produced.push_back(held[i]);
                in_escape  = 1'b0;
                held_count = 0;
            end
            if (produced.size() == 0) begin
                entry.value   = 8'h00;
                entry.present = 1'b0;
                entry.last    = 1'b1;
                due_bytes.push_back(entry);
                return;
            end
        end
        for (i = 0; i < produced.size(); i++) begin
            entry.value   = produced[i];
            entry.present = 1'b1;
            entry.last    = fin && (i == produced.size() - 1);
            due_bytes.push_back(entry);
        end
    endfunction

    // compare one popped result with the oldest due byte
    function void compare_byte(logic [7:0] value, logic present, logic last);
        decoded_byte_t want;
        if (due_bytes.size() == 0) begin
            $display("%0t: unexpected result out_byte %h byte_present %b end_of_literal %b",
                     $time, value, present, last);
            errors++;
            return;
        end
        want = due_bytes.pop_front();
        if (value !== want.value) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.value, value);
            errors++;
        end
        if (present !== want.present) begin
            $display("%0t: byte_present expected %b actual %b", $time, want.present, present);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: end_of_literal expected %b actual %b", $time, want.last, last);
            errors++;
        end
    endfunction
endclass

module tb_string_escape_decoder_core;

    localparam int RANDOM_ITEMS = 460;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 18;

    typedef enum int {
        ESC_CONTROL,
        ESC_HEX,
        ESC_DOLLAR,
        ESC_OCTAL,
        ESC_UNKNOWN,
        ESC_BACKSLASH
    } esc_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] character = 8'h00;
    logic       final_char = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_literal;

    decoded_byte_tracker tracker = new();
    logic [7:0]          body[$];
    int unsigned         sent_count = 0;
    int unsigned         cycle_count = 0;
    bit                  calm = 1'b0;

    string_escape_decoder_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .character      (character),
        .final_char     (final_char),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .byte_present   (byte_present),
        .end_of_literal (end_of_literal)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_string_escape_decoder_core: FAIL");
            $finish;
        end
    end

    // result side stalls at random, except during the calm stretch
    always @(posedge clk)
    begin
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watch both handshakes; values read here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                tracker.compare_byte(out_byte, byte_present, end_of_literal);
            if (push && !full)
                tracker.decode_char(character, final_char);
        end
    end

    // random digit character, now and then any byte
    function automatic logic [7:0] rand_digit();
        logic [7:0] r;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r = $urandom_range(0, 9);
            return CH_0 + r;
        end
        if (pick < 70) begin
            r = $urandom_range(0, 25);
            return CH_LA + r;
        end
        if (pick < 90) begin
            r = $urandom_range(0, 25);
            return CH_UA + r;
        end
        r = $urandom_range(0, 255);
        return r;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] r;
        r = $urandom_range(0, 255);
        while (r == CH_BSLASH) r = $urandom_range(0, 255);
        return r;
    endfunction

    // append one complete escape sequence of the given kind
    function automatic void add_escape(esc_kind_t kind);
        logic [7:0] r;
        body.push_back(CH_BSLASH);
        case (kind)
            ESC_CONTROL: begin
                r = $urandom_range(0, 2);
                body.push_back(r == 0 ? CH_N : (r == 1 ? CH_R : CH_T));
            end
            ESC_HEX: begin
                body.push_back(CH_0);
                body.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                body.push_back(rand_digit());
                body.push_back(rand_digit());
            end
            ESC_DOLLAR: begin
                body.push_back(CH_DOLLAR);
                body.push_back(rand_digit());
                body.push_back(rand_digit());
            end
            ESC_OCTAL: begin
                r = $urandom_range(0, 3);
                body.push_back(CH_0 + r);
                body.push_back(rand_digit());
                body.push_back(rand_digit());
            end
            ESC_UNKNOWN: begin
                r = $urandom_range(0, 255);
                while (r == CH_N || r == CH_R || r == CH_T || r == CH_DOLLAR ||
                       r == CH_BSLASH || (r >= CH_0 && r <= CH_3))
                    r = $urandom_range(0, 255);
                body.push_back(r);
            end
            default: body.push_back(CH_BSLASH);
        endcase
    endfunction

    // one request, held until the block takes it
    task automatic send_char(input logic [7:0] ch, input logic fin);
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge clk);
            end
        push       <= 1'b1;
        character  <= ch;
        final_char <= fin;
        do @(posedge clk); while (full);
        sent_count++;
    endtask

    task automatic send_body();
        int unsigned i;
        for (i = 0; i < body.size(); i++)
            send_char(body[i], i == body.size() - 1);
        body.delete();
    endtask

    initial
    begin
        int unsigned start_count;
        int unsigned pieces;
        int unsigned mark;
        int unsigned keep;
        int          pick;
        esc_kind_t   kind;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // control escapes, unknown escape, top plain byte
        body = {CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_T, CH_BSLASH, 8'h71, 8'hFF};
        send_body();
        // hex with upper x, dollar with letters past f, zero byte
        body = {CH_BSLASH, CH_0, CH_UX, 8'h46, 8'h66, CH_BSLASH, CH_DOLLAR, 8'h7A, 8'h5A, 8'h00};
        send_body();
        // escaped backslash, then largest octal
        body = {CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_3, 8'h37, 8'h37};
        send_body();
        // lone trailing backslash gives an empty end marker
        body = {CH_BSLASH};
        send_body();
        // hex escape cut short by the end of the literal
        body = {CH_BSLASH, CH_0, CH_LX, 8'h41};
        send_body();
        // cut short with a backslash as the final character
        body = {CH_BSLASH, CH_2, CH_BSLASH};
        send_body();

        // random literals, mostly well formed
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS) begin
            calm = (sent_count - start_count >= 180) && (sent_count - start_count < 280);
            pieces = $urandom_range(1, 6);
            repeat (pieces) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    body.push_back(rand_plain());
                else if (pick < 45)
                    body.push_back($urandom_range(0, 3) == 0 ? CH_BSLASH
                                                            : rand_plain());
                else begin
                    kind = esc_kind_t'($urandom_range(0, 5));
                    add_escape(kind);
                end
            end
            // broken tail: an escape cut short
            if ($urandom_range(0, 99) < 25) begin
                mark = body.size();
                kind = esc_kind_t'($urandom_range(0, 5));
                add_escape(kind);
                keep = $urandom_range(1, body.size() - mark - 1);
                while (body.size() > mark + keep) void'(body.pop_back());
            end
            send_body();
        end
        calm = 1'b0;
        push <= 1'b0;

        // drain, then give the block time to show anything extra
        while (tracker.due_bytes.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb_string_escape_decoder_core: PASS");
        else
            $display("tb_string_escape_decoder_core: FAIL");
        $finish;
    end

endmodule
